>>> rtl/core/uvsph_pkg.sv
// Shared types and constants of the UV sphere mesh point unit.
// Holds the beat structs, the register indexes and the CORDIC angle table.
// No dependencies.
package uvsph_pkg;

  localparam int IDX_W      = 8;
  localparam int POS_W      = 16;
  localparam int TEX_W      = 17;
  localparam int VIDX_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam int COORD_FRAC_BITS_DEF = 14;
  localparam int TRIG_STAGES_DEF     = 16;

  localparam logic [IDX_W-1:0] NUM_LAT_RESET  = 8'd16;
  localparam logic [IDX_W-1:0] NUM_LONG_RESET = 8'd32;

  // Inverse CORDIC gain in Q2.30.
  localparam logic signed [31:0] CORDIC_INV_GAIN = 32'sd652032874;

  // Arctangent of 2^-i as a fraction of a full turn (2^32 is one turn).
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_LAT  = 1'b0,
    REG_NUM_LONG = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0] lat_index;
    logic [IDX_W-1:0] long_index;
  } in_beat_t;

  typedef struct packed {
    logic                    point_valid;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic [VIDX_W-1:0]       vertex_index;
    logic                    quad_valid;
    logic [VIDX_W-1:0]       corner_below;
    logic [VIDX_W-1:0]       corner_diagonal;
    logic [VIDX_W-1:0]       corner_next;
  } out_beat_t;

endpackage

>>> rtl/core/uvsph_if.sv
// Valid/ready channel interfaces of the UV sphere mesh point unit.
// Depends on uvsph_pkg for the beat structs.
interface uvsph_in_if;
  logic                valid;
  logic                ready;
  uvsph_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface uvsph_out_if;
  logic                 valid;
  logic                 ready;
  uvsph_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/uv_sphere_mesh_point_unit.sv
// UV sphere mesh point unit: top level, the whole datapath in one pipeline.
// Depends on uvsph_pkg and the channel interfaces in uvsph_if.sv.
//
// The unit takes one grid point (latitude row, longitude column) per beat and
// returns one result beat with the unit-sphere position in signed Q1.14, the
// texture coordinates in Q1.16, the flat vertex index and, when the point
// starts a quad, the three other corner indices of its two triangles. A new
// point is accepted every clock cycle while the output buffer has a free
// entry. There are DIV_ST = 9 divider stages (up to four quotient bits per
// stage) and, by default, 16 CORDIC stages. The pipeline moves as a whole
// and a two-entry output buffer lets it keep accepting points while a
// finished result waits to be taken. The grid size registers may only be
// written while no point is in flight; the input, divider and format stages
// read them directly.
module uv_sphere_mesh_point_unit #(
  parameter int COORD_FRAC_BITS = uvsph_pkg::COORD_FRAC_BITS_DEF,
  parameter int TRIG_STAGES     = uvsph_pkg::TRIG_STAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [uvsph_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [uvsph_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  uvsph_in_if.sink                          in_i,
  uvsph_out_if.source                       out_o
);

  // Quotient Q = floor(index * 2^33 / n) has one leading bit and 33 more.
  localparam int DIV_BITS = 33;
  localparam int DIV_PER  = 4;
  localparam int DIV_ST   = (DIV_BITS + DIV_PER - 1) / DIV_PER;
  localparam int Q_W      = DIV_BITS + 1;
  // Stage map: input, divider, angle set-up, CORDIC, multiply, format.
  localparam int KA = DIV_ST + 1;
  localparam int KM = KA + TRIG_STAGES + 1;
  localparam int KO = KM + 1;
  localparam int N  = KO + 1;
  localparam int CW = 34;
  localparam int SHR = 60 - COORD_FRAC_BITS;

  typedef struct packed {
    logic                            pt;
    logic                            quad;
    logic [uvsph_pkg::VIDX_W-1:0]    vidx;
    logic [uvsph_pkg::TEX_W-1:0]     tex_u;
    logic [uvsph_pkg::TEX_W-1:0]     tex_v;
  } side_t;

  typedef struct packed {
    logic [uvsph_pkg::IDX_W-1:0] rem_a;
    logic [uvsph_pkg::IDX_W-1:0] rem_b;
    logic [Q_W-1:0]              q_a;
    logic [Q_W-1:0]              q_b;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } cor_t;

  // One restoring division step: returns the quotient bit above the new remainder.
  function automatic logic [uvsph_pkg::IDX_W:0] div_step(
    input logic [uvsph_pkg::IDX_W-1:0] rem,
    input logic [uvsph_pkg::IDX_W-1:0] n
  );
    logic [uvsph_pkg::IDX_W:0] r2;
    logic [uvsph_pkg::IDX_W:0] d;
    r2 = {rem, 1'b0};
    d  = r2 - {1'b0, n};
    if (r2 >= {1'b0, n}) begin
      return {1'b1, d[uvsph_pkg::IDX_W-1:0]};
    end
    return {1'b0, r2[uvsph_pkg::IDX_W-1:0]};
  endfunction

  // Folds angles of a quarter turn or more from zero back by half a turn.
  function automatic cor_t cor_init(input logic [31:0] a);
    cor_t c;
    logic [31:0] a2;
    c.flip = (a >= 32'h4000_0000) && (a < 32'hC000_0000);
    a2     = c.flip ? (a - 32'h8000_0000) : a;
    c.z    = CW'($signed(a2));
    c.x    = CW'(uvsph_pkg::CORDIC_INV_GAIN);
    c.y    = '0;
    return c;
  endfunction

  function automatic cor_t cor_iter(input cor_t c, input int sh, input logic [31:0] at);
    cor_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] atv;
    dx  = c.x >>> sh;
    dy  = c.y >>> sh;
    atv = CW'($signed({1'b0, at}));
    r.flip = c.flip;
    if (!c.z[CW-1]) begin
      r.x = c.x - dy;
      r.y = c.y + dx;
      r.z = c.z - atv;
    end else begin
      r.x = c.x + dy;
      r.y = c.y - dx;
      r.z = c.z + atv;
    end
    return r;
  endfunction

  // Rounds a Q60 product to the coordinate format and clamps it to +-1.0.
  function automatic logic [uvsph_pkg::POS_W-1:0] to_coord(input logic signed [63:0] p);
    logic signed [63:0] r;
    logic signed [63:0] lim;
    r   = (p + (64'sd1 <<< (SHR - 1))) >>> SHR;
    lim = 64'sd1 <<< COORD_FRAC_BITS;
    if (r > lim) begin
      r = lim;
    end
    if (r < -lim) begin
      r = -lim;
    end
    return r[uvsph_pkg::POS_W-1:0];
  endfunction

  logic [uvsph_pkg::IDX_W-1:0] num_lat_q;
  logic [uvsph_pkg::IDX_W-1:0] num_long_q;

  logic [N-1:0] valid_q;
  side_t        side_q [N];
  div_t         div_q  [DIV_ST+1];
  cor_t         cor_a_q [TRIG_STAGES+1];
  cor_t         cor_b_q [TRIG_STAGES+1];
  logic signed [63:0] prod_x_q;
  logic signed [63:0] prod_y_q;
  logic signed [31:0] cos_phi_q;
  uvsph_pkg::out_beat_t fmt_q;

  uvsph_pkg::out_beat_t slot0_q;
  uvsph_pkg::out_beat_t slot1_q;
  logic [1:0]           cnt_q;
  logic                 adv;
  logic                 push;
  logic                 pop;

  // The pipeline moves whenever the output buffer has a free entry.
  assign adv  = (cnt_q != 2'd2);
  assign push = adv && valid_q[N-1];
  assign pop  = (cnt_q != 2'd0) && out_o.ready;

  assign in_i.ready  = adv;
  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.data  = slot0_q;

  // Grid size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_lat_q  <= uvsph_pkg::NUM_LAT_RESET;
      num_long_q <= uvsph_pkg::NUM_LONG_RESET;
    end else if (cfg_we_i) begin
      unique case (uvsph_pkg::cfg_reg_e'(cfg_idx_i))
        uvsph_pkg::REG_NUM_LAT:  num_lat_q  <= cfg_data_i;
        uvsph_pkg::REG_NUM_LONG: num_long_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[N-2:0], in_i.valid};
    end
  end

  // Input stage: range checks, vertex index and the leading quotient bit.
  side_t side_in;
  div_t  div_in;
  always_comb begin
    logic [uvsph_pkg::IDX_W-1:0] lat;
    logic [uvsph_pkg::IDX_W-1:0] lo;
    logic [uvsph_pkg::IDX_W:0]   ng_p1;
    logic [16:0]                 vfull;
    logic                        qa;
    logic                        qb;
    lat   = in_i.data.lat_index;
    lo    = in_i.data.long_index;
    ng_p1 = {1'b0, num_long_q} + 9'd1;
    vfull = 17'(lat) * 17'(ng_p1) + 17'(lo);
    side_in.pt    = (num_lat_q != '0) && (num_long_q != '0) &&
                    (lat <= num_lat_q) && (lo <= num_long_q);
    side_in.quad  = side_in.pt && (lat < num_lat_q) && (lo < num_long_q);
    side_in.vidx  = vfull[uvsph_pkg::VIDX_W-1:0];
    side_in.tex_u = '0;
    side_in.tex_v = '0;
    qa = (lat >= num_lat_q);
    qb = (lo >= num_long_q);
    div_in.rem_a = qa ? (lat - num_lat_q) : lat;
    div_in.rem_b = qb ? (lo - num_long_q) : lo;
    div_in.q_a   = Q_W'(qa);
    div_in.q_b   = Q_W'(qb);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      div_q[0]  <= div_in;
    end
  end

  // Divider stages: up to DIV_PER quotient bits per stage for both axes.
  for (genvar d = 1; d <= DIV_ST; d++) begin : g_div
    div_t div_d;
    always_comb begin
      logic [uvsph_pkg::IDX_W:0] sa;
      logic [uvsph_pkg::IDX_W:0] sb;
      div_d = div_q[d-1];
      for (int j = 0; j < DIV_PER; j++) begin
        if ((d - 1) * DIV_PER + j < DIV_BITS) begin
          sa = div_step(div_d.rem_a, num_lat_q);
          sb = div_step(div_d.rem_b, num_long_q);
          div_d.rem_a = sa[uvsph_pkg::IDX_W-1:0];
          div_d.rem_b = sb[uvsph_pkg::IDX_W-1:0];
          div_d.q_a   = {div_d.q_a[Q_W-2:0], sa[uvsph_pkg::IDX_W]};
          div_d.q_b   = {div_d.q_b[Q_W-2:0], sb[uvsph_pkg::IDX_W]};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[d]  <= div_d;
        side_q[d] <= side_q[d-1];
      end
    end
  end

  // Angle set-up: rounded angles and texture coordinates from the quotients.
  side_t side_ka;
  cor_t  cor_a_in;
  cor_t  cor_b_in;
  always_comb begin
    logic [Q_W-1:0]  qa;
    logic [Q_W-1:0]  qb;
    logic [Q_W-1:0]  ta;
    logic [Q_W-1:0]  tb;
    logic [Q_W-16:0] ua;
    logic [Q_W-16:0] ub;
    logic [31:0]     phi;
    logic [31:0]     theta;
    qa    = div_q[DIV_ST].q_a;
    qb    = div_q[DIV_ST].q_b;
    ta    = {1'b0, qa[Q_W-1:1]} + Q_W'(1);
    tb    = qb + Q_W'(1);
    phi   = ta[32:1];
    theta = tb[32:1] + 32'h8000_0000;
    ua    = {1'b0, qb[Q_W-1:16]} + (Q_W-15)'(1);
    ub    = {1'b0, qa[Q_W-1:16]} + (Q_W-15)'(1);
    side_ka       = side_q[KA-1];
    side_ka.tex_u = ua[uvsph_pkg::TEX_W:1];
    side_ka.tex_v = ub[uvsph_pkg::TEX_W:1];
    cor_a_in      = cor_init(phi);
    cor_b_in      = cor_init(theta);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[KA]  <= side_ka;
      cor_a_q[0]  <= cor_a_in;
      cor_b_q[0]  <= cor_b_in;
    end
  end

  // CORDIC rotation stages, one micro-rotation per stage for phi and theta.
  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cor
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cor_a_q[i+1]   <= cor_iter(cor_a_q[i], i, uvsph_pkg::ATAN_TURNS[i]);
        cor_b_q[i+1]   <= cor_iter(cor_b_q[i], i, uvsph_pkg::ATAN_TURNS[i]);
        side_q[KA+1+i] <= side_q[KA+i];
      end
    end
  end

  // Multiply stage: undo the half-turn fold and form the Q60 products.
  always_ff @(posedge clk_i) begin
    logic signed [CW-1:0] cp;
    logic signed [CW-1:0] sp;
    logic signed [CW-1:0] ct;
    logic signed [CW-1:0] st;
    cp = cor_a_q[TRIG_STAGES].flip ? -cor_a_q[TRIG_STAGES].x : cor_a_q[TRIG_STAGES].x;
    sp = cor_a_q[TRIG_STAGES].flip ? -cor_a_q[TRIG_STAGES].y : cor_a_q[TRIG_STAGES].y;
    ct = cor_b_q[TRIG_STAGES].flip ? -cor_b_q[TRIG_STAGES].x : cor_b_q[TRIG_STAGES].x;
    st = cor_b_q[TRIG_STAGES].flip ? -cor_b_q[TRIG_STAGES].y : cor_b_q[TRIG_STAGES].y;
    if (adv) begin
      prod_x_q   <= $signed(ct[31:0]) * $signed(sp[31:0]);
      prod_y_q   <= $signed(st[31:0]) * $signed(sp[31:0]);
      cos_phi_q  <= cp[31:0];
      side_q[KM] <= side_q[KM-1];
    end
  end

  // Format stage: rounding, clamping, corner indices and zeroing.
  uvsph_pkg::out_beat_t fmt_d;
  always_comb begin
    side_t s;
    logic signed [63:0] pz;
    s  = side_q[KM];
    pz = 64'(cos_phi_q) <<< 30;
    fmt_d = '0;
    if (s.pt) begin
      fmt_d.point_valid  = 1'b1;
      fmt_d.pos_x        = to_coord(prod_x_q);
      fmt_d.pos_y        = to_coord(prod_y_q);
      fmt_d.pos_z        = to_coord(pz);
      fmt_d.tex_u        = s.tex_u;
      fmt_d.tex_v        = s.tex_v;
      fmt_d.vertex_index = s.vidx;
      if (s.quad) begin
        fmt_d.quad_valid      = 1'b1;
        fmt_d.corner_below    = s.vidx + uvsph_pkg::VIDX_W'(num_long_q) + 16'd1;
        fmt_d.corner_diagonal = s.vidx + uvsph_pkg::VIDX_W'(num_long_q) + 16'd2;
        fmt_d.corner_next     = s.vidx + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fmt_q      <= fmt_d;
      side_q[KO] <= side_q[KM];
    end
  end

  // Two-entry output buffer; slot0 is the head shown on the output channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cnt_q)
      2'd0: begin
        if (push) begin
          slot0_q <= fmt_q;
        end
      end
      2'd1: begin
        if (push && pop) begin
          slot0_q <= fmt_q;
        end else if (push) begin
          slot1_q <= fmt_q;
        end
      end
      2'd2: begin
        if (pop) begin
          slot0_q <= slot1_q;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> tb/uv_sphere_mesh_point_unit_tb.sv
// Self-checking testbench of the UV sphere mesh point unit.
// Depends on uvsph_pkg, the channel interfaces in uvsph_if.sv and the unit itself.
// Drives grid points and compares every result beat with a built-in predictor.
`timescale 1ns / 100ps

module uv_sphere_mesh_point_unit_tb;

  localparam int LATENCY = 9 + uvsph_pkg::TRIG_STAGES_DEF + 5;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [uvsph_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [uvsph_pkg::CFG_DATA_W-1:0] cfg_data_i;

  uvsph_in_if  in_ch ();
  uvsph_out_if out_ch ();

  uv_sphere_mesh_point_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  // Grid size as the predictor sees it; it follows every register write.
  logic [7:0] grid_lat;
  logic [7:0] grid_long;

  uvsph_pkg::in_beat_t  point_queue[$];
  uvsph_pkg::out_beat_t expected_points[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_sender;
  int  fail_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Arithmetic shift right of a signed value rounds toward minus infinity.
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Rotation CORDIC on an angle given as a fraction of a turn; results Q2.30.
  function automatic void rotate_angle(input logic [31:0] angle, output longint cos_q,
                                       output longint sin_q);
    bit flip;
    longint x, y, z, dx, dy;
    logic [31:0] a;
    flip = 1'b0;
    x = longint'(uvsph_pkg::CORDIC_INV_GAIN);
    y = 0;
    a = angle;
    // Angles in the left half plane are turned by pi first.
    if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
      a = a - 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'($signed(a));
    for (int i = 0; i < uvsph_pkg::TRIG_STAGES_DEF; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(uvsph_pkg::ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(uvsph_pkg::ATAN_TURNS[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cos_q = x;
    sin_q = y;
  endfunction

  // Rounds a Q60 product to the coordinate format and clamps it to +-1.0.
  function automatic logic [15:0] q60_to_coord(longint p);
    int     s;
    longint lim, r;
    s = 60 - uvsph_pkg::COORD_FRAC_BITS_DEF;
    lim = longint'(1) << uvsph_pkg::COORD_FRAC_BITS_DEF;
    r = floor_shr(p + (longint'(1) << (s - 1)), s);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

  function automatic uvsph_pkg::out_beat_t predict_mesh_point(uvsph_pkg::in_beat_t pt);
    uvsph_pkg::out_beat_t res;
    longint unsigned lat, lo, nl, ng, vidx;
    logic [31:0] phi, theta;
    longint      cp, sp, ct, st;
    res = '0;
    lat = 64'(pt.lat_index);
    lo  = 64'(pt.long_index);
    nl  = 64'(grid_lat);
    ng  = 64'(grid_long);
    if (nl == 0 || ng == 0 || lat > nl || lo > ng) return res;
    phi   = 32'(((lat << 32) + nl) / (2 * nl));
    theta = 32'(((lo << 33) + ng) / (2 * ng) + 64'h8000_0000);
    rotate_angle(phi, cp, sp);
    rotate_angle(theta, ct, st);
    res.point_valid = 1'b1;
    res.pos_x = q60_to_coord(ct * sp);
    res.pos_y = q60_to_coord(st * sp);
    res.pos_z = q60_to_coord(cp * (longint'(1) << 30));
    res.tex_u = 17'(((lo << 17) + ng) / (2 * ng));
    res.tex_v = 17'(((lat << 17) + nl) / (2 * nl));
    vidx = (lat * (ng + 1) + lo) & 64'hFFFF;
    res.vertex_index = vidx[15:0];
    // Only points that start a quad carry the other three corners.
    if (lat < nl && lo < ng) begin
      res.quad_valid      = 1'b1;
      res.corner_below    = 16'(vidx + ng + 1);
      res.corner_diagonal = 16'(vidx + ng + 2);
      res.corner_next     = 16'(vidx + 1);
    end
    return res;
  endfunction

  // Driver: one point per beat from the pending queue, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_points.push_back(predict_mesh_point(in_ch.data));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (point_queue.size() > 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= point_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result beat with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    uvsph_pkg::out_beat_t exp_pt;
    uvsph_pkg::out_beat_t got;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
          fail_count++;
        end else begin
          exp_pt = expected_points.pop_front();
          if (got.point_valid !== exp_pt.point_valid) begin
            $display("%0t: point_valid expected %0d actual %0d", $time,
                     exp_pt.point_valid, got.point_valid);
            fail_count++;
          end
          if (got.pos_x !== exp_pt.pos_x) begin
            $display("%0t: pos_x expected %0d actual %0d", $time, exp_pt.pos_x, got.pos_x);
            fail_count++;
          end
          if (got.pos_y !== exp_pt.pos_y) begin
            $display("%0t: pos_y expected %0d actual %0d", $time, exp_pt.pos_y, got.pos_y);
            fail_count++;
          end
          if (got.pos_z !== exp_pt.pos_z) begin
            $display("%0t: pos_z expected %0d actual %0d", $time, exp_pt.pos_z, got.pos_z);
            fail_count++;
          end
          if (got.tex_u !== exp_pt.tex_u) begin
            $display("%0t: tex_u expected %0d actual %0d", $time, exp_pt.tex_u, got.tex_u);
            fail_count++;
          end
          if (got.tex_v !== exp_pt.tex_v) begin
            $display("%0t: tex_v expected %0d actual %0d", $time, exp_pt.tex_v, got.tex_v);
            fail_count++;
          end
          if (got.vertex_index !== exp_pt.vertex_index) begin
            $display("%0t: vertex_index expected %0d actual %0d", $time,
                     exp_pt.vertex_index, got.vertex_index);
            fail_count++;
          end
          if (got.quad_valid !== exp_pt.quad_valid) begin
            $display("%0t: quad_valid expected %0d actual %0d", $time,
                     exp_pt.quad_valid, got.quad_valid);
            fail_count++;
          end
          if (got.corner_below !== exp_pt.corner_below) begin
            $display("%0t: corner_below expected %0d actual %0d", $time,
                     exp_pt.corner_below, got.corner_below);
            fail_count++;
          end
          if (got.corner_diagonal !== exp_pt.corner_diagonal) begin
            $display("%0t: corner_diagonal expected %0d actual %0d", $time,
                     exp_pt.corner_diagonal, got.corner_diagonal);
            fail_count++;
          end
          if (got.corner_next !== exp_pt.corner_next) begin
            $display("%0t: corner_next expected %0d actual %0d", $time,
                     exp_pt.corner_next, got.corner_next);
            fail_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Waits until every queued point has been sent and every result taken.
  task automatic drain_pipeline();
    while (point_queue.size() > 0 || in_ch.valid || expected_points.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // Register writes happen only here, with nothing in flight. The extra edge
  // at the end keeps two back-to-back writes in separate time steps.
  task automatic write_grid_reg(uvsph_pkg::cfg_reg_e idx, logic [7:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == uvsph_pkg::REG_NUM_LAT) grid_lat = value;
    else grid_long = value;
    @(posedge clk_i);
  endtask

  task automatic queue_point(logic [7:0] lat, logic [7:0] lo);
    uvsph_pkg::in_beat_t pt;
    pt.lat_index  = lat;
    pt.long_index = lo;
    point_queue.push_back(pt);
  endtask

  // A random phase: mostly points inside the grid, some on its last row,
  // and a few anywhere in the index range.
  task automatic queue_random_points(int count);
    int sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        queue_point(8'($urandom_range(grid_lat)), 8'($urandom_range(grid_long)));
      end else if (sel < 85) begin
        queue_point(grid_lat, 8'($urandom_range(grid_long)));
      end else begin
        queue_point(8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    fail_count    = 0;
    hold_sender   = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 55;
    grid_lat      = uvsph_pkg::NUM_LAT_RESET;
    grid_long     = uvsph_pkg::NUM_LONG_RESET;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = uvsph_pkg::REG_NUM_LAT;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset grid: poles, seam, last row and column,
    // points just outside, and the largest indices.
    queue_point(0, 0);
    queue_point(16, 32);
    queue_point(8, 0);
    queue_point(8, 8);
    queue_point(8, 16);
    queue_point(8, 24);
    queue_point(15, 31);
    queue_point(16, 5);
    queue_point(3, 32);
    queue_point(17, 0);
    queue_point(0, 33);
    queue_point(255, 255);
    queue_point(8'hAA, 8'h55);
    queue_point(8'h55, 8'hAA);
    drain_pipeline();

    // Largest grid: the last vertex index reaches the top of the 16-bit range.
    write_grid_reg(uvsph_pkg::REG_NUM_LAT, 8'd255);
    write_grid_reg(uvsph_pkg::REG_NUM_LONG, 8'd255);
    queue_point(255, 255);
    queue_point(254, 254);
    queue_point(255, 0);
    queue_point(128, 64);
    drain_pipeline();

    // An empty grid rejects every point.
    write_grid_reg(uvsph_pkg::REG_NUM_LAT, 8'd0);
    queue_point(0, 0);
    queue_point(1, 1);
    drain_pipeline();
    write_grid_reg(uvsph_pkg::REG_NUM_LAT, 8'd4);
    write_grid_reg(uvsph_pkg::REG_NUM_LONG, 8'd0);
    queue_point(0, 0);
    drain_pipeline();

    // Smallest grid.
    write_grid_reg(uvsph_pkg::REG_NUM_LONG, 8'd1);
    write_grid_reg(uvsph_pkg::REG_NUM_LAT, 8'd1);
    queue_point(0, 0);
    queue_point(1, 1);
    queue_point(0, 1);
    drain_pipeline();

    // Random phases over several grids and idle patterns.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 55;
        recv_idle_pct = 17;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_grid_reg(uvsph_pkg::REG_NUM_LAT,
                     (ph % 4 == 0) ? 8'd255 : 8'($urandom_range(1, 40)));
      write_grid_reg(uvsph_pkg::REG_NUM_LONG,
                     (ph % 4 == 1) ? 8'd255 : 8'($urandom_range(1, 80)));
      queue_random_points(50);
      if (ph == 4) begin
        // Hold the sender until the pipeline has emptied out.
        while (point_queue.size() > 25) @(posedge clk_i);
        hold_sender = 1'b1;
        while (in_ch.valid || expected_points.size() > 0) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      drain_pipeline();
    end

    repeat (LATENCY) @(posedge clk_i);
    if (fail_count == 0 && expected_points.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (expected_points.size() > 0) begin
        $display("%0t: %0d results never arrived", $time, expected_points.size());
      end
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
